// File: rtl/core/pbfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbfr_pkg: shared types and helpers for the page bitmap free-run summary
// Lane and word summary records, count widths and saturating arithmetic.
// ----------------------------------------------------------------------------
package pbfr_pkg;

	localparam int WORDS_PER_CHUNK = 8;
	localparam int BITS_PER_WORD   = 64;
	localparam int LANE_W          = 8;
	localparam int LANES           = BITS_PER_WORD / LANE_W;

	localparam int POS_W  = (WORDS_PER_CHUNK > 1) ? $clog2(WORDS_PER_CHUNK) : 1;
	localparam int LCNT_W = $clog2(LANE_W + 1);
	localparam int WCNT_W = $clog2(BITS_PER_WORD + 1);
	localparam int CNT_W  = 10;
	localparam int OUT_W  = 3 * CNT_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [POS_W-1:0] LAST_POS  = POS_W'(WORDS_PER_CHUNK - 1);

	// What one lane of eight pages holds.
	typedef struct packed {
		logic              all_free;
		logic [LCNT_W-1:0] lead;
		logic [LCNT_W-1:0] longest;
		logic [LCNT_W-1:0] trail;
	} lane_sum_t;

	// What one whole word of pages holds.
	typedef struct packed {
		logic              all_free;
		logic [WCNT_W-1:0] lead;
		logic [WCNT_W-1:0] longest;
		logic [WCNT_W-1:0] trail;
	} word_sum_t;

	// One finished chunk summary.
	typedef struct packed {
		logic [CNT_W-1:0] trailing_free;
		logic [CNT_W-1:0] longest_free;
		logic [CNT_W-1:0] leading_free;
	} chunk_sum_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [WCNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + (CNT_W + 1)'(b);
		return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] cnt_max(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/pbfr_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbfr_lane: free-run summary of one lane of pages
// Finds leading, longest and trailing free runs within eight page bits.
// ----------------------------------------------------------------------------
module pbfr_lane
	import pbfr_pkg::*;
(
	input  wire logic [LANE_W-1:0] bits,
	output lane_sum_t              lane_sum
);

	always_comb begin
		logic [LCNT_W-1:0] cur;
		logic [LCNT_W-1:0] best;
		logic [LCNT_W-1:0] lead;
		logic              open;
		cur  = '0;
		best = '0;
		lead = '0;
		open = 1'b1;
		for (int k = 0; k < LANE_W; k++) begin
			if (bits[k]) begin
				cur  = '0;
				open = 1'b0;
			end else begin
				cur = cur + LCNT_W'(1);
				if (cur > best) begin
					best = cur;
				end
				if (open) begin
					lead = lead + LCNT_W'(1);
				end
			end
		end
		lane_sum.all_free = open;
		lane_sum.lead     = lead;
		lane_sum.longest  = best;
		lane_sum.trail    = cur;
	end

endmodule
`default_nettype wire

// File: rtl/core/pbfr_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbfr_merge: joins the lane summaries of one word
// Walks the lanes from the lowest pages up and builds the word summary.
// ----------------------------------------------------------------------------
module pbfr_merge
	import pbfr_pkg::*;
(
	input  lane_sum_t lanes [LANES],
	output word_sum_t word_sum
);

	always_comb begin
		logic [WCNT_W-1:0] cur;
		logic [WCNT_W-1:0] best;
		logic [WCNT_W-1:0] lead;
		logic [WCNT_W-1:0] joined;
		logic              open;
		cur    = '0;
		best   = '0;
		lead   = '0;
		joined = '0;
		open   = 1'b1;
		for (int i = 0; i < LANES; i++) begin
			if (lanes[i].all_free) begin
				cur = cur + WCNT_W'(LANE_W);
				if (open) begin
					lead = lead + WCNT_W'(LANE_W);
				end
			end else begin
				// The open run ends inside this lane, after its leading pages.
				joined = cur + WCNT_W'(lanes[i].lead);
				if (joined > best) begin
					best = joined;
				end
				if (WCNT_W'(lanes[i].longest) > best) begin
					best = WCNT_W'(lanes[i].longest);
				end
				if (open) begin
					lead = lead + WCNT_W'(lanes[i].lead);
				end
				open = 1'b0;
				cur  = WCNT_W'(lanes[i].trail);
			end
		end
		if (cur > best) begin
			best = cur;
		end
		word_sum.all_free = open;
		word_sum.lead     = lead;
		word_sum.longest  = best;
		word_sum.trail    = cur;
	end

endmodule
`default_nettype wire

// File: rtl/core/pbfr_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pbfr_accum: chunk accumulator and result register
// Folds word summaries into the chunk counts and holds the finished result.
// ----------------------------------------------------------------------------
module pbfr_accum
	import pbfr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic upd,
	input  wire logic last,
	input  word_sum_t word_sum,
	input  wire logic res_ready,
	output logic      res_valid,
	output chunk_sum_t res
);

	logic [CNT_W-1:0] lead_q;
	logic [CNT_W-1:0] best_q;
	logic [CNT_W-1:0] cur_q;
	logic             open_q;

	logic [CNT_W-1:0] lead_n;
	logic [CNT_W-1:0] best_n;
	logic [CNT_W-1:0] cur_n;
	logic             open_n;

	always_comb begin
		logic [CNT_W-1:0] joined;
		joined = sat_add(cur_q, word_sum.lead);
		lead_n = open_q ? sat_add(lead_q, word_sum.lead) : lead_q;
		open_n = open_q & word_sum.all_free;
		if (word_sum.all_free) begin
			cur_n  = sat_add(cur_q, word_sum.trail);
			best_n = cnt_max(best_q, cur_n);
		end else begin
			cur_n  = CNT_W'(word_sum.trail);
			best_n = cnt_max(cnt_max(best_q, joined), CNT_W'(word_sum.longest));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			best_q <= '0;
			cur_q  <= '0;
			open_q <= 1'b1;
		end else if (upd) begin
			if (last) begin
				lead_q <= '0;
				best_q <= '0;
				cur_q  <= '0;
				open_q <= 1'b1;
			end else begin
				lead_q <= lead_n;
				best_q <= best_n;
				cur_q  <= cur_n;
				open_q <= open_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (upd && last) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd && last) begin
			res.leading_free  <= lead_n;
			res.longest_free  <= best_n;
			res.trailing_free <= cur_n;
		end
	end

	// A result only appears straight after the last word of a chunk.
	a_res_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(upd && last))
		else $error("result raised without a closing word");

	// Leading and trailing runs are runs too, so never beat the longest.
	a_counts_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.leading_free <= res.longest_free &&
			res.trailing_free <= res.longest_free))
		else $error("end runs exceed the longest run");

	// A chunk closes with the running state cleared for the next one.
	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && last) |=> (open_q && cur_q == '0 && best_q == '0 && lead_q == '0))
		else $error("chunk state not cleared after the last word");

	// While no used page has been seen the leading count tracks the open run.
	a_open_lead: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (lead_q == cur_q))
		else $error("leading count parted from the open run");

endmodule
`default_nettype wire

// File: rtl/core/page_bitmap_free_run_summary.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_bitmap_free_run_summary: free-run summary of a page bitmap chunk
// Counts leading, longest and trailing free pages over a chunk of words.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata                                     Beats per chunk
//  s_axis   in   page_word[63:0], 1 = page used            WORDS_PER_CHUNK
//  m_axis   out  leading[9:0] longest[19:10] trailing[29:20] 1
//
// One word is taken every clock cycle while the input is not stalled; each
// word passes three stages: eight lanes of eight pages each, a merging stage
// that joins the lanes, then the chunk accumulator, whose result register
// drives the output.  A result is offered once the last word of its chunk has
// passed the lane and merge registers and been folded in by the accumulator.
// The input only stalls when a closing word reaches the accumulator while the
// previous result is still waiting to be taken.  Reset clears the word
// position, the stage valid bits, the chunk counts and the result valid flag.
//
module page_bitmap_free_run_summary
	import pbfr_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [BITS_PER_WORD-1:0] s_tdata,   // page_word[63:0]
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [OUT_TDATA_W-1:0]        m_tdata    // leading_free, longest_free,
	                                                 // trailing_free, zero pad
);

	// Position of the next word within its chunk; the last position closes it.
	logic [POS_W-1:0] pos_q;
	logic             in_beat;
	logic             hold;
	logic             advance;

	lane_sum_t lane_sum [LANES];
	lane_sum_t lane_s1  [LANES];
	logic      valid_s1;
	logic      last_s1;

	word_sum_t word_sum;
	word_sum_t word_s2;
	logic      valid_s2;
	logic      last_s2;

	chunk_sum_t res;

	// The whole pipeline moves together; it only waits when a finished chunk
	// would overwrite a result that has not been taken.
	assign hold     = m_tvalid & ~m_tready & valid_s2 & last_s2;
	assign advance  = ~hold;
	assign s_tready = advance;
	assign in_beat  = s_tvalid & s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_beat) begin
			pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
		end
	end

	// Stage one: each lane summarises its eight pages.
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		pbfr_lane u_lane (
			.bits     (s_tdata[g*LANE_W +: LANE_W]),
			.lane_sum (lane_sum[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lane_s1 <= lane_sum;
			last_s1 <= (pos_q == LAST_POS);
		end
	end

	// Stage two: the lanes are joined into one word summary.
	pbfr_merge u_merge (
		.lanes    (lane_s1),
		.word_sum (word_sum)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s2 <= word_sum;
			last_s2 <= last_s1;
		end
	end

	// Stage three: the word is folded into the chunk counts.
	pbfr_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (valid_s2 & advance),
		.last      (last_s2),
		.word_sum  (word_s2),
		.res_ready (m_tready),
		.res_valid (m_tvalid),
		.res       (res)
	);

	assign m_tdata = OUT_TDATA_W'(res.trailing_free) << (2 * CNT_W)
		| OUT_TDATA_W'(res.longest_free) << CNT_W
		| OUT_TDATA_W'(res.leading_free);

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the page bitmap free-run summary
// Streams chunks of page bitmap words into the block, folds every accepted
// beat into a local model of the three free-page counts and compares each
// summary beat with the oldest predicted summary.
// ----------------------------------------------------------------------------
module tb;
	import pbfr_pkg::*;

	localparam int RAND_CHUNKS    = 106;   // 848 random page words
	localparam int DIR_ROWS       = 3 * WORDS_PER_CHUNK;
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
	localparam int HOLD_CYCLES    = 300;   // the one long output stall
	localparam int MAX_REPORTS    = 10;

	// One row of the directed table.  Where the summary is obvious it is
	// written in by hand; otherwise the local model supplies it.
	typedef struct {
		logic [BITS_PER_WORD-1:0] page_word;
		bit                       typed;
		chunk_sum_t               summary;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [BITS_PER_WORD-1:0] s_tdata;   // page_word[63:0]
	logic                     m_tvalid;
	logic                     m_tready;
	logic [OUT_TDATA_W-1:0]   m_tdata;   // leading_free, longest_free,
	                                     // trailing_free, zero pad

	// Local copy of the chunk scan state.
	int               chunk_pos;
	logic [CNT_W-1:0] lead_cnt;
	bit               lead_open;
	logic [CNT_W-1:0] best_cnt;
	logic [CNT_W-1:0] open_run;

	chunk_sum_t summary_q[$];   // summaries still owed by the block
	dir_row_t   dir_tab[DIR_ROWS];

	int  words_taken;
	int  chunks_sent;
	int  summaries_seen;
	int  errors;
	int  idle_cycles;
	int  hold_left;
	bit  hold_done;

	page_bitmap_free_run_summary u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Counts saturate rather than wrap; with eight words per chunk the ceiling
	// is never reached, but the model keeps the rule all the same.
	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

	// Fold one page word into the scan state, pages in ascending order.  On
	// the closing word of a chunk the finished summary is handed back and
	// the state starts afresh.
	task automatic fold_page_word(input logic [BITS_PER_WORD-1:0] w,
			output bit closed, output chunk_sum_t sum);
		int k;
		sum = '0;
		for (k = 0; k < BITS_PER_WORD; k++) begin
			if (w[k]) begin
				open_run  = '0;
				lead_open = 1'b0;
			end else begin
				open_run = bump(open_run);
				if (open_run > best_cnt)
					best_cnt = open_run;
				if (lead_open)
					lead_cnt = bump(lead_cnt);
			end
		end
		closed = (chunk_pos == WORDS_PER_CHUNK - 1);
		if (closed) begin
			sum.leading_free  = lead_cnt;
			sum.longest_free  = best_cnt;
			sum.trailing_free = open_run;
			chunk_pos = 0;
			lead_cnt  = '0;
			lead_open = 1'b1;
			best_cnt  = '0;
			open_run  = '0;
		end else begin
			chunk_pos++;
		end
	endtask

	// Offer one word and hold it until the block takes it.  The sender idles
	// at random, except over a stretch in the middle of the random part.
	task automatic offer_word(input logic [BITS_PER_WORD-1:0] w, input bit typed,
			input chunk_sum_t typed_sum);
		bit         closed;
		chunk_sum_t sum;
		@(negedge clk);
		while (!(words_taken >= 400 && words_taken < 560) &&
				$urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		do @(posedge clk); while (!s_tready);
		words_taken++;
		fold_page_word(w, closed, sum);
		if (closed) begin
			summary_q.push_back(typed ? typed_sum : sum);
			chunks_sent++;
		end
	endtask

	// Stimulus: directed chunks, then random chunks, then the drain.
	initial begin
		int                       c;
		int                       i;
		int                       len;
		int                       pos;
		logic [BITS_PER_WORD-1:0] w;
		logic [BITS_PER_WORD-1:0] mask;
		logic [3:0]               chunk_kind;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;
		chunk_pos = 0;
		lead_cnt  = '0;
		lead_open = 1'b1;
		best_cnt  = '0;
		open_run  = '0;
		words_taken = 0;
		chunks_sent = 0;
		hold_left   = 0;
		hold_done   = 1'b0;

		// First chunk fully free, second fully used, third a mix of edge
		// patterns whose counts come from the model.
		for (i = 0; i < WORDS_PER_CHUNK; i++) begin
			dir_tab[i] = '{page_word: '0, typed: 1'b0, summary: '0};
			dir_tab[WORDS_PER_CHUNK + i] = '{page_word: '1, typed: 1'b0, summary: '0};
		end
		dir_tab[WORDS_PER_CHUNK - 1].typed   = 1'b1;
		dir_tab[WORDS_PER_CHUNK - 1].summary = '{
			trailing_free: CNT_W'(WORDS_PER_CHUNK * BITS_PER_WORD),
			longest_free:  CNT_W'(WORDS_PER_CHUNK * BITS_PER_WORD),
			leading_free:  CNT_W'(WORDS_PER_CHUNK * BITS_PER_WORD)};
		dir_tab[2 * WORDS_PER_CHUNK - 1].typed   = 1'b1;
		dir_tab[2 * WORDS_PER_CHUNK - 1].summary = '0;
		dir_tab[16] = '{page_word: 64'h8000_0000_0000_0000, typed: 1'b0, summary: '0};
		dir_tab[17] = '{page_word: 64'h0000_0000_0000_0001, typed: 1'b0, summary: '0};
		dir_tab[18] = '{page_word: 64'h5555_5555_5555_5555, typed: 1'b0, summary: '0};
		dir_tab[19] = '{page_word: 64'hAAAA_AAAA_AAAA_AAAA, typed: 1'b0, summary: '0};
		dir_tab[20] = '{page_word: 64'h0000_0000_0000_0000, typed: 1'b0, summary: '0};
		dir_tab[21] = '{page_word: 64'h0000_0000_0000_0000, typed: 1'b0, summary: '0};
		dir_tab[22] = '{page_word: 64'hFFFF_FFFF_FFFF_FFFF, typed: 1'b0, summary: '0};
		dir_tab[23] = '{page_word: 64'h7FFF_FFFF_FFFF_FFFF, typed: 1'b0, summary: '0};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < DIR_ROWS; i++)
			offer_word(dir_tab[i].page_word, dir_tab[i].typed, dir_tab[i].summary);

		// Random chunks.  Some are wholly free or wholly used; the rest mix
		// word shapes so that runs start, stop and cross word boundaries.
		for (c = 0; c < RAND_CHUNKS; c++) begin
			chunk_kind = 4'($urandom_range(0, 9));
			for (i = 0; i < WORDS_PER_CHUNK; i++) begin
				len  = $urandom_range(1, BITS_PER_WORD);
				pos  = $urandom_range(0, BITS_PER_WORD - len);
				mask = (len == BITS_PER_WORD) ? '1 : (((64'd1 << len) - 64'd1) << pos);
				if (chunk_kind == 0)
					w = '0;
				else if (chunk_kind == 1)
					w = '1;
				else begin
					case ($urandom_range(0, 7))
						0: w = '0;
						1: w = '1;
						2: w = 64'd1 << $urandom_range(0, BITS_PER_WORD - 1);
						3: w = ~(64'd1 << $urandom_range(0, BITS_PER_WORD - 1));
						4: w = ~mask;   // one free run
						5: w = mask;    // one used run
						default: w = {$urandom, $urandom};
					endcase
				end
				offer_word(w, 1'b0, '0);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain: the watchdog covers the case where a summary never comes.
		wait (summary_q.size() == 0);
		repeat (8) @(posedge clk);

		$display("Summary: %0d page words in %0d chunks, %0d summaries checked.",
			words_taken, chunks_sent, summaries_seen);
		$display("Covered: fully free and fully used chunks, edge words, random runs,"
			, " and one long output stall with the input backed up.");
		if (errors == 0 && summary_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Receiver: random back-pressure, a stretch with none, and one long hold
	// once enough words have gone in for the pipeline to fill and stall.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && words_taken >= 600) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (summaries_seen >= 20 && summaries_seen < 35) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// Compare every summary beat with the oldest owed summary.
	always @(posedge clk) begin
		chunk_sum_t want;
		chunk_sum_t got;
		logic [OUT_TDATA_W-OUT_W-1:0] pad;
		if (arst_n && m_tvalid && m_tready) begin
			got = chunk_sum_t'(m_tdata[OUT_W-1:0]);
			pad = m_tdata[OUT_TDATA_W-1:OUT_W];
			summaries_seen++;
			if (summary_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: summary beat with none owed: lead %0d longest %0d trail %0d",
						$realtime, got.leading_free, got.longest_free, got.trailing_free);
			end else begin
				want = summary_q.pop_front();
				if (got.leading_free !== want.leading_free ||
						got.longest_free !== want.longest_free ||
						got.trailing_free !== want.trailing_free || pad !== '0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: summary %0d wrong: lead %0d/%0d longest %0d/%0d trail %0d/%0d pad %b (exp/got)",
							$realtime, summaries_seen, want.leading_free, got.leading_free,
							want.longest_free, got.longest_free,
							want.trailing_free, got.trailing_free, pad);
				end
			end
		end
	end

	// Watchdog: a run in which no beat moves on either side for too long has
	// hung.
	initial begin
		errors = 0;
		summaries_seen = 0;
		idle_cycles = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat moved for %0d cycles, %0d summaries still owed",
					WATCHDOG_LIMIT, summary_q.size());
				$display("DONE: errors detected");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
